[sv/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// bcd_pkg
// shared types and constants for the button click event detector
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int LIMIT_WIDTH = 16;
  localparam int COUNT_WIDTH = LIMIT_WIDTH + 1;
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  typedef logic [LIMIT_WIDTH-1:0] limit_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_DCLICK   = 2'd2,
    REG_IDLE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    limit_t debounce_limit;
    limit_t long_press_limit;
    limit_t double_click_limit;
    logic   idle_level_load;
    logic   idle_level_new;
  } cfg_t;

endpackage

[sv/bcd_regs.sv]
// ----------------------------------------------------------------------------
// bcd_regs
// apb register file holding the timing limits and the idle level
// ----------------------------------------------------------------------------
module bcd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcd_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [bcd_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [bcd_pkg::DATA_WIDTH-1:0] prdata,
  output logic                         pready,
  output bcd_pkg::cfg_t                cfg
);
  import bcd_pkg::*;

  limit_t   debounce_limit;
  limit_t   long_press_limit;
  limit_t   double_click_limit;
  logic     idle_level;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit     <= limit_t'(50);
      long_press_limit   <= limit_t'(1000);
      double_click_limit <= limit_t'(300);
      idle_level         <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: debounce_limit     <= pwdata[LIMIT_WIDTH-1:0];
        REG_LONG:     long_press_limit   <= pwdata[LIMIT_WIDTH-1:0];
        REG_DCLICK:   double_click_limit <= pwdata[LIMIT_WIDTH-1:0];
        REG_IDLE:     idle_level         <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE: prdata[LIMIT_WIDTH-1:0] = debounce_limit;
      REG_LONG:     prdata[LIMIT_WIDTH-1:0] = long_press_limit;
      REG_DCLICK:   prdata[LIMIT_WIDTH-1:0] = double_click_limit;
      REG_IDLE:     prdata[0]               = idle_level;
      default:      prdata = '0;
    endcase
  end

  assign cfg.debounce_limit     = debounce_limit;
  assign cfg.long_press_limit   = long_press_limit;
  assign cfg.double_click_limit = double_click_limit;
  // the core reloads its last level when idle and not accepting a tick
  assign cfg.idle_level_load    = wr_en && (idx == REG_IDLE);
  assign cfg.idle_level_new     = pwdata[0];

endmodule

[sv/bcd_core.sv]
// ----------------------------------------------------------------------------
// bcd_core
// debounce and click classification state machine, one tick per request
// ----------------------------------------------------------------------------
module bcd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             pin_level,
  input  bcd_pkg::cfg_t    cfg,
  output bcd_pkg::event_t  ev
);
  import bcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE             = 3'd0,
    ST_DEBOUNCE         = 3'd1,
    ST_CLICK_WAIT       = 3'd2,
    ST_DCLICK_WAIT      = 3'd3,
    ST_DCLICK_DEBOUNCE  = 3'd4,
    ST_RELEASE_WAIT     = 3'd5,
    ST_RELEASE_DEBOUNCE = 3'd6
  } state_t;

  state_t state, state_next;
  logic   last_level, last_level_next;
  count_t debounce_count, debounce_count_next;
  count_t hold_count, hold_count_next;
  count_t gap_count, gap_count_next;
  count_t db_inc, hold_inc, gap_inc;
  logic   changed;
  logic   db_done, hold_done, gap_done;

  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + count_t'(1);
  endfunction

  assign db_inc    = bump(debounce_count);
  assign hold_inc  = bump(hold_count);
  assign gap_inc   = bump(gap_count);
  assign db_done   = db_inc > {1'b0, cfg.debounce_limit};
  assign hold_done = hold_inc > {1'b0, cfg.long_press_limit};
  assign gap_done  = gap_inc > {1'b0, cfg.double_click_limit};
  assign changed   = pin_level != last_level;

  always_comb begin
    state_next          = state;
    last_level_next     = last_level;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    gap_count_next      = gap_count;
    ev                  = EV_NONE;
    unique case (state)
      ST_IDLE: begin
        if (changed) begin
          last_level_next     = pin_level;
          debounce_count_next = '0;
          state_next          = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        debounce_count_next = db_inc;
        if (db_done) begin
          if (!changed) begin
            hold_count_next = '0;
            state_next      = ST_CLICK_WAIT;
          end else begin
            last_level_next = pin_level;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_CLICK_WAIT: begin
        hold_count_next = hold_inc;
        if (changed) begin
          last_level_next = pin_level;
          gap_count_next  = '0;
          state_next      = ST_DCLICK_WAIT;
        end
        // timeout beats a level change in the same tick
        if (hold_done) begin
          ev         = EV_LONG;
          state_next = ST_RELEASE_WAIT;
        end
      end
      ST_DCLICK_WAIT: begin
        gap_count_next = gap_inc;
        if (changed) begin
          last_level_next     = pin_level;
          debounce_count_next = '0;
          state_next          = ST_DCLICK_DEBOUNCE;
        end
        if (gap_done) begin
          ev         = EV_CLICK;
          state_next = ST_IDLE;
        end
      end
      ST_DCLICK_DEBOUNCE: begin
        debounce_count_next = db_inc;
        if (db_done) begin
          if (!changed) begin
            ev         = EV_DOUBLE;
            state_next = ST_RELEASE_WAIT;
          end else begin
            last_level_next = pin_level;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_RELEASE_WAIT: begin
        if (changed) begin
          last_level_next     = pin_level;
          debounce_count_next = '0;
          state_next          = ST_RELEASE_DEBOUNCE;
        end
      end
      ST_RELEASE_DEBOUNCE: begin
        debounce_count_next = db_inc;
        if (db_done) begin
          last_level_next = pin_level;
          state_next      = ST_IDLE;
        end
      end
      default: ;  // unused code holds
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      last_level     <= 1'b1;
      debounce_count <= '0;
      hold_count     <= '0;
      gap_count      <= '0;
    end else if (accept) begin
      state          <= state_next;
      last_level     <= last_level_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      gap_count      <= gap_count_next;
    end else if (cfg.idle_level_load && state == ST_IDLE) begin
      last_level <= cfg.idle_level_new;
    end
  end

endmodule

[sv/bcd_outq.sv]
// ----------------------------------------------------------------------------
// bcd_outq
// two-entry result buffer between the state machine and the output channel
// ----------------------------------------------------------------------------
module bcd_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bcd_pkg::event_t wr_data,
  output logic            has_room,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bcd_pkg::event_t rd_data
);
  import bcd_pkg::*;

  event_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign has_room = !count[1];
  assign rd_valid = count != 2'd0;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[sv/button_click_event_detector_unit.sv]
// ----------------------------------------------------------------------------
// button_click_event_detector_unit
// debounced click, double click and long press detector, one tick per request
// ----------------------------------------------------------------------------
// results: registered in the result buffer when the tick is accepted, offered
// behind older results; throughput: one tick per cycle while the buffer has room
// a two-entry result buffer keeps ticks flowing while one result waits
// reset: synchronous, limits return to 50/1000/300, idle level 1, machine idle
// ----------------------------------------------------------------------------
module button_click_event_detector_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pin_level,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic [1:0]                     event_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcd_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [bcd_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [bcd_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import bcd_pkg::*;

  cfg_t   cfg;
  event_t ev;
  event_t rd_ev;
  logic   accept;

  assign accept     = in_valid && in_ready;
  assign event_code = rd_ev;

  bcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pin_level (pin_level),
    .cfg       (cfg),
    .ev        (ev)
  );

  bcd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (ev),
    .has_room (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (rd_ev)
  );

endmodule

[test/tb_button_click_event_detector_unit.sv]
// ----------------------------------------------------------------------------
// tb_button_click_event_detector_unit
// checks click, double click and long press detection tick by tick against
// a cycle-free behavioral predictor, across several limit and idle settings
// ----------------------------------------------------------------------------
module tb_button_click_event_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bcd_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;

  typedef enum logic [2:0] {
    ST_IDLE            = 3'd0,
    ST_DEBOUNCE        = 3'd1,
    ST_CLICK_WAIT      = 3'd2,
    ST_DCLICK_WAIT     = 3'd3,
    ST_DCLICK_DEBOUNCE = 3'd4,
    ST_RELEASE_WAIT    = 3'd5,
    ST_RELEASE_DEBOUNCE = 3'd6
  } det_state_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pin_level = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            event_code;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  button_click_event_detector_unit uut (
    .clk        (clk),
    .rst        (rst),
    .pin_level  (pin_level),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_code (event_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial forever #5 clk = ~clk;

  // predictor copy of the limits and the detector state
  limit_t     dbn_lim = 16'd50;
  limit_t     hold_lim = 16'd1000;
  limit_t     gap_lim = 16'd300;
  logic       idle_lvl = 1'b1;
  det_state_t det_state = ST_IDLE;
  logic       last_lvl = 1'b1;
  count_t     dbn_cnt = '0;
  count_t     hold_cnt = '0;
  count_t     gap_cnt = '0;

  bit          tick_q[$];
  event_t      event_q[$];
  event_t      want_ev;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  bit          tick_taken = 1'b0;

  function automatic count_t bump_count(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic event_t step_detector(input logic lvl);
    event_t ev;
    logic   changed;
    ev = EV_NONE;
    changed = (lvl != last_lvl);
    case (det_state)
      ST_IDLE: begin
        if (changed) begin
          last_lvl = lvl;
          dbn_cnt = '0;
          det_state = ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        dbn_cnt = bump_count(dbn_cnt);
        if (dbn_cnt > dbn_lim) begin
          if (!changed) begin
            hold_cnt = '0;
            det_state = ST_CLICK_WAIT;
          end else begin
            last_lvl = lvl;
            det_state = ST_IDLE;
          end
        end
      end
      ST_CLICK_WAIT: begin
        hold_cnt = bump_count(hold_cnt);
        if (changed) begin
          last_lvl = lvl;
          gap_cnt = '0;
          det_state = ST_DCLICK_WAIT;
        end
        // the long press timeout overrides a release on the same tick
        if (hold_cnt > hold_lim) begin
          ev = EV_LONG;
          det_state = ST_RELEASE_WAIT;
        end
      end
      ST_DCLICK_WAIT: begin
        gap_cnt = bump_count(gap_cnt);
        if (changed) begin
          last_lvl = lvl;
          dbn_cnt = '0;
          det_state = ST_DCLICK_DEBOUNCE;
        end
        if (gap_cnt > gap_lim) begin
          ev = EV_CLICK;
          det_state = ST_IDLE;
        end
      end
      ST_DCLICK_DEBOUNCE: begin
        dbn_cnt = bump_count(dbn_cnt);
        if (dbn_cnt > dbn_lim) begin
          if (!changed) begin
            ev = EV_DOUBLE;
            det_state = ST_RELEASE_WAIT;
          end else begin
            last_lvl = lvl;
            det_state = ST_IDLE;
          end
        end
      end
      ST_RELEASE_WAIT: begin
        if (changed) begin
          last_lvl = lvl;
          dbn_cnt = '0;
          det_state = ST_RELEASE_DEBOUNCE;
        end
      end
      ST_RELEASE_DEBOUNCE: begin
        dbn_cnt = bump_count(dbn_cnt);
        if (dbn_cnt > dbn_lim) begin
          last_lvl = lvl;
          det_state = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    return ev;
  endfunction

  // one apb transfer; a write updates the predictor, a read is checked
  task automatic apb_access(input reg_idx_t idx, input bit wr, input int unsigned value);
    int unsigned mask;
    int unsigned word;
    mask = (idx == REG_IDLE) ? 32'h1 : 32'hFFFF;
    word = ($urandom & ~mask) | (value & mask);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      case (idx)
        REG_DEBOUNCE: dbn_lim = word[LIMIT_WIDTH-1:0];
        REG_LONG:     hold_lim = word[LIMIT_WIDTH-1:0];
        REG_DCLICK:   gap_lim = word[LIMIT_WIDTH-1:0];
        REG_IDLE: begin
          idle_lvl = word[0];
          if (det_state == ST_IDLE) last_lvl = word[0];
        end
        default: begin
        end
      endcase
    end else if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d readback expected %0h actual %0h",
               $time, idx, value & mask, prdata & mask);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned d, input int unsigned lp,
                               input int unsigned dc, input bit il);
    apb_access(REG_DEBOUNCE, 1'b1, d);
    apb_access(REG_LONG, 1'b1, lp);
    apb_access(REG_DCLICK, 1'b1, dc);
    apb_access(REG_IDLE, 1'b1, il);
    apb_access(REG_DEBOUNCE, 1'b0, dbn_lim);
    apb_access(REG_LONG, 1'b0, hold_lim);
    apb_access(REG_DCLICK, 1'b0, gap_lim);
    apb_access(REG_IDLE, 1'b0, idle_lvl);
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_pattern(input string s);
    for (int i = 0; i < s.len(); i++) tick_q.push_back(s.getc(i) == "1");
  endtask

  task automatic push_level(input bit lvl, input int unsigned n);
    repeat (n) tick_q.push_back(lvl);
  endtask

  // a length close to a limit, or a short one when the limit is huge
  function automatic int unsigned span(input int unsigned lim);
    int unsigned v;
    if (lim > 40) return $urandom_range(1, 40);
    v = lim + $urandom_range(0, 2);
    return (v > 1) ? v - 1 : 1;
  endfunction

  function automatic int unsigned pick_limit(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    return $urandom_range(0, hi);
  endfunction

  task automatic add_gesture();
    int unsigned d;
    int unsigned lp;
    int unsigned dc;
    bit          up;
    bit          dn;
    d = dbn_lim;
    lp = hold_lim;
    dc = gap_lim;
    up = idle_lvl;
    dn = ~idle_lvl;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        push_level(dn, span(d) + 1 + $urandom_range(0, 3));
        push_level(up, span(dc) + span(d) + 1);
      end
      3, 4, 5: begin
        push_level(dn, span(d) + 2);
        push_level(up, span(dc));
        push_level(dn, span(d) + 2);
        push_level(up, span(d) + 2);
      end
      6, 7: begin
        push_level(dn, span(d) + span(lp) + 2);
        push_level(up, span(d) + 2);
      end
      8: begin
        repeat ($urandom_range(1, 4)) push_level(1'($urandom_range(0, 1)), span(d));
      end
      default: begin
        repeat ($urandom_range(1, 8)) push_level(1'($urandom_range(0, 1)), 1);
      end
    endcase
  endtask

  // sender: bursts of requests separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!rst && (!in_valid || tick_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        pin_level <= tick_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  always @(negedge clk) begin
    // start the hold-off only while plenty of requests are still queued
    if (!held_once && ticks_sent >= 300 && tick_q.size() >= 10) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      case (rx_cycle[7:6])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      tick_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          $display("%0t: unexpected event expected none actual %0d", $time, event_code);
          errors++;
        end else begin
          want_ev = event_q.pop_front();
          if (event_code !== want_ev) begin
            $display("%0t: event mismatch expected %0d actual %0d",
                     $time, want_ev, event_code);
            errors++;
          end
        end
      end
      if (tick_taken) begin
        event_q.push_back(step_detector(pin_level));
        ticks_sent++;
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (tick_q.size() == 0 && !in_valid && event_q.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned phase_start;
    int unsigned phase_no;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: click, double click, long press, and a release on the long press tick
    apply_setting(0, 2, 1, 1'b1);
    push_pattern("00111");
    push_pattern("0010011");
    push_pattern("0000011");
    push_pattern("00001");
    push_pattern("00110");
    push_pattern("1");
    drain();

    total = 0;
    phase_no = 0;
    while (total < 1050) begin
      case (phase_no)
        0:       apply_setting(0, 0, 0, 1'b0);
        1:       apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        default: apply_setting(pick_limit(6), pick_limit(40), pick_limit(20),
                               1'($urandom_range(0, 1)));
      endcase
      phase_start = tick_q.size();
      while (tick_q.size() - phase_start < 70) add_gesture();
      // sometimes stop mid-press so the next setting lands on a running count
      if ($urandom_range(0, 1))
        push_level(~idle_lvl, span(dbn_lim) + span(hold_lim) / 2 + 1);
      total += tick_q.size() - phase_start;
      phase_no++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
